>>> sv/wpd_pkg.sv
package wpd_pkg;

  // Fixed-point units: pt in 1/16 GeV; eta, phi and distances in 1/1024
  localparam int PI_UNITS        = 3217;
  localparam int TWO_PI_UNITS    = 6434;
  localparam int PT_MIN_UNITS    = 8;
  localparam int RADIUS_NUM      = 49152;
  localparam int RADIUS_PT_FLOOR = 16;
  localparam int RADIUS_MIN      = 51;
  localparam int RADIUS_MAX      = 102;
  localparam int STRIP_FLOOR     = 51;
  localparam int PHI_CAP         = 307;
  localparam int ETA_CAP         = 153;
  localparam int MEAN_MAX        = 16383;

  // Strip window power laws: coefficient scaled by 2^26, exponent by 2^16
  localparam longint unsigned PHI_COEF = 64'd23654264;
  localparam longint          PHI_EXP  = 64'sd46381;
  localparam longint unsigned ETA_COEF = 64'd13225614;
  localparam longint          ETA_EXP  = 64'sd43169;

  localparam int LIMIT_TABLE_DEPTH_DEF = 256;
  localparam int WIN_W                 = 9;

  // Input actions
  localparam logic [1:0] ACT_BEGIN  = 2'd0;
  localparam logic [1:0] ACT_PHOTON = 2'd1;
  localparam logic [1:0] ACT_FINISH = 2'd2;

  // Selection modes (meaning flips with the three-prong flag)
  localparam logic [1:0] SEL_INNER = 2'd0;
  localparam logic [1:0] SEL_OUTER = 2'd1;
  localparam logic [1:0] SEL_ALL   = 2'd2;

  // Distance kinds
  localparam logic [1:0] DIST_DR   = 2'd0;
  localparam logic [1:0] DIST_DETA = 2'd1;
  localparam logic [1:0] DIST_DPHI = 2'd2;

  // Register indexes
  localparam logic REG_SELECT_MODE   = 1'b0;
  localparam logic REG_DISTANCE_KIND = 1'b1;

  typedef logic [WIN_W-1:0] win_t;

  // Integer square root, floored
  function automatic longint unsigned isqrt64(input longint unsigned v_in);
    longint unsigned v;
    longint unsigned r;
    longint unsigned b;
    v = v_in;
    r = 64'd0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 64'd0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // log2 with 16 fraction bits, truncated
  function automatic longint log2_q16(input int unsigned x_in);
    int unsigned     x;
    int unsigned     n;
    int unsigned     frac;
    longint unsigned y;
    int              b;
    x = (x_in == 0) ? 1 : x_in;
    n = 0;
    frac = 0;
    while (n < 15 && (x >> (n + 1)) != 0) n++;
    y = longint'(x) << (30 - n);
    for (b = 15; b >= 0; b--) begin
      y = (y * y) >> 30;
      if (y >= (64'd1 << 31)) begin
        y = y >> 1;
        frac = frac | (32'd1 << b);
      end
    end
    return longint'(n) * 65536 + longint'(frac);
  endfunction

  // floor(1024 * c * (idx/16)^-p)
  function automatic longint unsigned power_limit(input int unsigned idx,
                                                  input longint unsigned coef,
                                                  input longint expo);
    longint          t;
    longint          prod;
    longint          e;
    longint          k;
    longint          f;
    longint unsigned r;
    longint unsigned root;
    longint unsigned v;
    int              j;
    t = log2_q16(idx) - 4 * 65536;
    prod = expo * t;
    e = (-prod) / 65536;
    if (e >= 0) begin
      k = e / 65536;
      f = e % 65536;
    end else begin
      k = -((-e + 65535) / 65536);
      f = e - k * 65536;
    end
    r = 64'd1 << 30;
    root = 64'd1 << 31;
    for (j = 0; j < 16; j++) begin
      root = isqrt64(root << 30);
      if (((($unsigned(f)) >> (15 - j)) & 64'd1) != 64'd0) r = (r * root) >> 30;
    end
    v = (coef * r) >> 30;
    if (k >= 0) v = (k > 8) ? (v << 8) : (v << k);
    else v = (k < -40) ? 64'd0 : (v >> (-k));
    return v >> 16;
  endfunction

  function automatic win_t strip_window(input int unsigned idx,
                                        input longint unsigned coef,
                                        input longint expo,
                                        input int unsigned cap);
    longint unsigned l;
    l = power_limit(idx, coef, expo);
    if (l < STRIP_FLOOR) l = STRIP_FLOOR;
    if (l > cap) l = cap;
    return WIN_W'(l);
  endfunction

endpackage

>>> sv/pt_weighted_photon_distance.sv
// Begin runs the radius division; a photon runs distance, square, square root and selection,
// and multiply and accumulate when selected; a photon below 0.5 GeV is dropped while idle.
// Finish runs the mean division (cut short on saturation, skipped if nothing was summed) and
// waits while the previous result is not yet taken. Items are taken only while idle; the shared
// 41-bit subtract/compare unit produces one quotient bit or one root bit per cycle over 15 steps.
// Reset (rst, synchronous): registers to 0, sums and reference cleared, output idle.
module pt_weighted_photon_distance
  import wpd_pkg::*;
#(
  parameter int LIMIT_TABLE_DEPTH = LIMIT_TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         action,
  input  logic [15:0]        ref_pt,
  input  logic signed [13:0] ref_eta,
  input  logic signed [12:0] ref_phi,
  input  logic               three_prong,
  input  logic [15:0]        cand_pt,
  input  logic signed [13:0] photon_eta,
  input  logic signed [12:0] photon_phi,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [13:0]        mean_distance,
  output logic               any_selected
);

  localparam int TIW = (LIMIT_TABLE_DEPTH > 1) ? $clog2(LIMIT_TABLE_DEPTH) : 1;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DIV     = 4'd1;
  localparam logic [3:0] S_DIV_END = 4'd2;
  localparam logic [3:0] S_EMIT    = 4'd3;
  localparam logic [3:0] S_DIST    = 4'd4;
  localparam logic [3:0] S_SQ      = 4'd5;
  localparam logic [3:0] S_SQRT    = 4'd6;
  localparam logic [3:0] S_SEL     = 4'd7;
  localparam logic [3:0] S_MUL     = 4'd8;
  localparam logic [3:0] S_ACC     = 4'd9;

  localparam logic [3:0] STEP_TOP = 4'd14;

  logic [3:0]         state;
  logic [3:0]         step;
  logic               op_mean;
  logic [39:0]        rem;
  logic [25:0]        dvs;
  logic [13:0]        quot;
  logic               sat;
  logic [13:0]        mean_hold;

  logic [1:0]         select_mode;
  logic [1:0]         distance_kind;
  logic signed [13:0] held_eta;
  logic signed [12:0] held_phi;
  logic               held_three_prong;
  logic [6:0]         cone_radius;
  logic [25:0]        pt_sum;
  logic [39:0]        weighted_sum;

  logic [15:0]        p_pt;
  logic signed [13:0] p_eta;
  logic signed [12:0] p_phi;
  logic [13:0]        deta;
  logic [11:0]        dphi;
  win_t               w_phi;
  win_t               w_eta;
  logic [28:0]        sq;
  logic [29:0]        root;
  logic               take;
  logic [14:0]        dx;
  logic [30:0]        prod;

  // Strip window tables, one entry per clamped photon pt
  win_t phi_win_tab [LIMIT_TABLE_DEPTH];
  win_t eta_win_tab [LIMIT_TABLE_DEPTH];

  for (genvar g = 0; g < LIMIT_TABLE_DEPTH; g++) begin : g_win
    assign phi_win_tab[g] = strip_window(g, PHI_COEF, PHI_EXP, PHI_CAP);
    assign eta_win_tab[g] = strip_window(g, ETA_COEF, ETA_EXP, ETA_CAP);
  end

  // Configuration port
  logic cfg_we;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[2])
      REG_SELECT_MODE:   prdata = {30'b0, select_mode};
      REG_DISTANCE_KIND: prdata = {30'b0, distance_kind};
      default:           prdata = 32'b0;
    endcase
  end

  assign in_ready = (state == S_IDLE);

  // Shared subtract/compare unit: divider and square-root steps
  logic [40:0] unit_a;
  logic [40:0] unit_b;
  logic [40:0] unit_diff;
  logic        unit_ge;
  logic [29:0] sq_bit;

  assign sq_bit = 30'd1 << {step, 1'b0};

  always_comb begin
    case (state)
      S_DIV: begin
        unit_a = {1'b0, rem};
        unit_b = {1'b0, 40'(dvs) << step};
      end
      S_SQRT: begin
        unit_a = {12'b0, sq};
        unit_b = {11'b0, root + sq_bit};
      end
      default: begin
        unit_a = '0;
        unit_b = '0;
      end
    endcase
  end

  assign unit_diff = unit_a - unit_b;
  assign unit_ge   = !unit_diff[40];

  // Photon distances against the held reference
  logic signed [14:0] d_eta;
  logic [14:0]        deta_abs;
  logic signed [13:0] d_phi;
  logic [12:0]        dphi_abs;
  logic [12:0]        dphi_mod;
  logic [11:0]        dphi_fold;
  logic [TIW-1:0]     tab_idx;

  always_comb begin
    d_eta = {p_eta[13], p_eta} - {held_eta[13], held_eta};
    deta_abs = d_eta[14] ? 15'(-d_eta) : 15'(d_eta);
    d_phi = {p_phi[12], p_phi} - {held_phi[12], held_phi};
    dphi_abs = d_phi[13] ? 13'(-d_phi) : 13'(d_phi);
    dphi_mod = (dphi_abs >= 13'(TWO_PI_UNITS)) ? dphi_abs - 13'(TWO_PI_UNITS) : dphi_abs;
    dphi_fold = (dphi_mod > 13'(PI_UNITS)) ? 12'(13'(TWO_PI_UNITS) - dphi_mod)
                                           : dphi_mod[11:0];
    tab_idx = (p_pt > 16'(LIMIT_TABLE_DEPTH - 1)) ? TIW'(LIMIT_TABLE_DEPTH - 1)
                                                  : p_pt[TIW-1:0];
  end

  // Squares of the distances
  logic [27:0] sq_eta;
  logic [23:0] sq_phi;
  assign sq_eta = deta * deta;
  assign sq_phi = dphi * dphi;

  // Selection and distance choice
  logic [14:0] dr;
  logic        in_strip;
  logic        take_c;
  logic [14:0] dx_c;

  always_comb begin
    dr = root[14:0];
    in_strip = (dphi <= 12'(w_phi)) && (deta <= 14'(w_eta));
    if (!held_three_prong) begin
      take_c = (select_mode == SEL_ALL) ||
               (select_mode == SEL_INNER && dr < 15'(cone_radius)) ||
               (select_mode == SEL_OUTER && dr > 15'(cone_radius));
    end else begin
      take_c = (select_mode == SEL_INNER) ||
               (select_mode == SEL_OUTER && in_strip) ||
               (select_mode == SEL_ALL && !in_strip);
    end
    case (distance_kind)
      DIST_DR:   dx_c = dr;
      DIST_DETA: dx_c = {1'b0, deta};
      DIST_DPHI: dx_c = {3'b0, dphi};
      default:   dx_c = '0;
    endcase
  end

  // Saturating accumulation
  logic [26:0] ps_add;
  logic [40:0] ws_add;
  assign ps_add = {1'b0, pt_sum} + 27'(p_pt);
  assign ws_add = {1'b0, weighted_sum} + 41'(prod);

  // Clamped cone radius from the divider quotient
  logic [6:0] radius_c;
  assign radius_c = (quot < 14'(RADIUS_MIN)) ? 7'(RADIUS_MIN) :
                    (quot > 14'(RADIUS_MAX)) ? 7'(RADIUS_MAX) : quot[6:0];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      select_mode <= '0;
      distance_kind <= '0;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_SELECT_MODE:   select_mode <= pwdata[1:0];
        REG_DISTANCE_KIND: distance_kind <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      held_eta <= '0;
      held_phi <= '0;
      held_three_prong <= 1'b0;
      cone_radius <= '0;
      pt_sum <= '0;
      weighted_sum <= '0;
    end else begin
      // drop the result once transferred, unless a new one is loaded
      if (out_valid && out_ready && state != S_EMIT) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            case (action)
              ACT_BEGIN: begin
                held_eta <= ref_eta;
                held_phi <= ref_phi;
                held_three_prong <= three_prong;
                pt_sum <= '0;
                weighted_sum <= '0;
                rem <= 40'(RADIUS_NUM);
                dvs <= (ref_pt < 16'(RADIUS_PT_FLOOR)) ? 26'(RADIUS_PT_FLOOR) : 26'(ref_pt);
                op_mean <= 1'b0;
                quot <= '0;
                sat <= 1'b0;
                step <= STEP_TOP;
                state <= S_DIV;
              end
              ACT_PHOTON: begin
                if (cand_pt >= 16'(PT_MIN_UNITS)) begin
                  p_pt <= cand_pt;
                  p_eta <= photon_eta;
                  p_phi <= photon_phi;
                  state <= S_DIST;
                end
              end
              ACT_FINISH: begin
                if (pt_sum == '0) begin
                  mean_hold <= '0;
                  state <= S_EMIT;
                end else begin
                  rem <= weighted_sum;
                  dvs <= pt_sum;
                  op_mean <= 1'b1;
                  quot <= '0;
                  sat <= 1'b0;
                  step <= STEP_TOP;
                  state <= S_DIV;
                end
              end
              default: ;
            endcase
          end
        end

        // restoring division, top step is the overflow check
        S_DIV: begin
          if (step == STEP_TOP) begin
            if (unit_ge) begin
              sat <= 1'b1;
              state <= S_DIV_END;
            end else begin
              step <= step - 4'd1;
            end
          end else begin
            if (unit_ge) rem <= unit_diff[39:0];
            quot <= {quot[12:0], unit_ge};
            if (step == 4'd0) state <= S_DIV_END;
            else step <= step - 4'd1;
          end
        end

        S_DIV_END: begin
          if (op_mean) begin
            mean_hold <= sat ? 14'(MEAN_MAX) : quot;
            state <= S_EMIT;
          end else begin
            cone_radius <= radius_c;
            state <= S_IDLE;
          end
        end

        // hold until the output register is free
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            mean_distance <= mean_hold;
            any_selected <= (pt_sum != '0);
            state <= S_IDLE;
          end
        end

        S_DIST: begin
          deta <= deta_abs[13:0];
          dphi <= dphi_fold;
          w_phi <= phi_win_tab[tab_idx];
          w_eta <= eta_win_tab[tab_idx];
          state <= S_SQ;
        end

        S_SQ: begin
          sq <= 29'(sq_eta) + 29'(sq_phi);
          root <= '0;
          step <= STEP_TOP;
          state <= S_SQRT;
        end

        // one root bit per step
        S_SQRT: begin
          if (unit_ge) begin
            sq <= unit_diff[28:0];
            root <= (root >> 1) + sq_bit;
          end else begin
            root <= root >> 1;
          end
          if (step == 4'd0) state <= S_SEL;
          else step <= step - 4'd1;
        end

        S_SEL: begin
          take <= take_c;
          dx <= dx_c;
          state <= take_c ? S_MUL : S_IDLE;
        end

        S_MUL: begin
          prod <= p_pt * dx;
          state <= S_ACC;
        end

        S_ACC: begin
          if (take) begin
            pt_sum <= ps_add[26] ? '1 : ps_add[25:0];
            weighted_sum <= ws_add[40] ? '1 : ws_add[39:0];
          end
          state <= S_IDLE;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // A begin always leaves a radius inside its clamp range
  a_radius_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_END && !op_mean) |=>
      (cone_radius >= 7'(RADIUS_MIN) && cone_radius <= 7'(RADIUS_MAX)))
    else $error("cone radius out of range after begin");

  // A nonzero mean needs summed pt
  a_mean_needs_pt: assert property (@(posedge clk) disable iff (rst)
    (out_valid && mean_distance != '0) |-> any_selected)
    else $error("nonzero mean without selected pt");

  // Soft photons leave the sequencer idle
  a_soft_photon: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && action == ACT_PHOTON && cand_pt < 16'(PT_MIN_UNITS))
      |=> (state == S_IDLE && $stable(pt_sum) && $stable(weighted_sum)))
    else $error("soft photon changed the sums");

  // The weighted sum changes only in the accumulate step or on begin
  a_sum_update: assert property (@(posedge clk) disable iff (rst)
    (state != S_ACC && !(state == S_IDLE && in_valid && action == ACT_BEGIN))
      |=> $stable(weighted_sum))
    else $error("weighted sum changed outside accumulation");

endmodule

>>> test/pt_weighted_photon_distance_tb.sv
`timescale 1ns / 1ps

module pt_weighted_photon_distance_tb;
  import wpd_pkg::*;

  // Action code the block ignores
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // Fixed-point geometry and limits
  localparam int HALF_TURN      = 3217;
  localparam int FULL_TURN      = 6434;
  localparam int SOFT_PT        = 8;
  localparam int CONE_NUM       = 49152;
  localparam int CONE_PT_FLOOR  = 16;
  localparam int CONE_MIN       = 51;
  localparam int CONE_MAX       = 102;
  localparam int WINDOW_FLOOR   = 51;
  localparam int PHI_WINDOW_CAP = 307;
  localparam int ETA_WINDOW_CAP = 153;
  localparam int WINDOW_TOP     = 255;
  localparam int MEAN_CEIL      = 16383;
  localparam longint unsigned PT_TOTAL_MAX = (64'd1 << 26) - 1;
  localparam longint unsigned WEIGHTED_MAX = (64'd1 << 40) - 1;

  // Strip power laws: coefficient scaled by 2^26, exponent by 2^16
  localparam longint unsigned PHI_LAW_COEF = 64'd23654264;
  localparam longint          PHI_LAW_EXP  = 46381;
  localparam longint unsigned ETA_LAW_COEF = 64'd13225614;
  localparam longint          ETA_LAW_EXP  = 43169;

  localparam int SETTLE_CYCLES = 32;
  localparam int LONG_HOLD     = 600;
  localparam int PHASE_ITEMS   = 38;
  localparam int HARD_PHOTONS  = 20;

  typedef struct {
    logic [1:0]         action;
    logic [15:0]        ref_pt;
    logic signed [13:0] ref_eta;
    logic signed [12:0] ref_phi;
    logic               three_prong;
    logic [15:0]        cand_pt;
    logic signed [13:0] photon_eta;
    logic signed [12:0] photon_phi;
  } photon_item_t;

  typedef struct {
    logic [13:0] mean;
    logic        any;
  } mean_result_t;

  // Tracks reference state and sums, and holds the expected finish results
  class photon_mean_board;
    logic [1:0]      select_mode;
    logic [1:0]      distance_kind;
    int              held_eta;
    int              held_phi;
    bit              held_three_prong;
    int              cone_radius;
    longint unsigned pt_total;
    longint unsigned weighted_total;
    int              phi_window[256];
    int              eta_window[256];
    mean_result_t    mean_queue[$];
    int              failures;

    function new();
      select_mode = SEL_INNER;
      distance_kind = DIST_DR;
      held_eta = 0;
      held_phi = 0;
      held_three_prong = 0;
      cone_radius = 0;
      pt_total = 0;
      weighted_total = 0;
      failures = 0;
      for (int i = 0; i <= WINDOW_TOP; i++) begin
        phi_window[i] = strip_limit(i, PHI_LAW_COEF, PHI_LAW_EXP, PHI_WINDOW_CAP);
        eta_window[i] = strip_limit(i, ETA_LAW_COEF, ETA_LAW_EXP, ETA_WINDOW_CAP);
      end
    endfunction

    // Floored square root, one bit at a time from the top
    function longint unsigned root_floor(longint unsigned v);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if (t * t <= v) r = t;
      end
      return r;
    endfunction

    // log2 in Q16, truncated, by repeated squaring of the mantissa
    function longint log2_fixed(int unsigned x);
      int unsigned     xv;
      int unsigned     n;
      longint unsigned y;
      longint          frac;
      xv = (x == 0) ? 1 : x;
      n = 0;
      frac = 0;
      while (n < 15 && (xv >> (n + 1)) != 0) n++;
      y = 64'(xv) << (30 - n);
      for (int b = 15; b >= 0; b--) begin
        y = (y * y) >> 30;
        if (y >= (64'd1 << 31)) begin
          y = y >> 1;
          frac += longint'(1) << b;
        end
      end
      return longint'(n) * 65536 + frac;
    endfunction

    // Window W = clamp(floor(1024 * c * (idx/16)^-p), floor, cap)
    function int strip_limit(int unsigned idx, longint unsigned coef, longint expo, int cap);
      longint          expn;
      longint          whole;
      longint unsigned frac;
      longint unsigned acc;
      longint unsigned root;
      longint unsigned v;
      expn = -(expo * (log2_fixed(idx) - 262144)) / 65536;
      whole = expn >>> 16;
      frac = expn & 64'hFFFF;
      acc = 64'd1 << 30;
      root = 64'd1 << 31;
      // walk the chain 2^(1/2), 2^(1/4), ... and multiply in the set fraction bits
      for (int j = 0; j < 16; j++) begin
        root = root_floor(root << 30);
        if (frac[15 - j]) acc = (acc * root) >> 30;
      end
      v = (coef * acc) >> 30;
      if (whole >= 0) v = v << ((whole > 8) ? 8 : whole);
      else if (whole < -40) v = 0;
      else v = v >> (-whole);
      v = v >> 16;
      if (v < WINDOW_FLOOR) v = WINDOW_FLOOR;
      if (v > cap) v = cap;
      return int'(v);
    endfunction

    function void set_register(logic idx, logic [1:0] value);
      if (idx == REG_SELECT_MODE) select_mode = value;
      else distance_kind = value;
    endfunction

    // Advance the sums for one accepted transfer
    function void absorb_item(photon_item_t it);
      int unsigned pt;
      int          d;
      int          deta;
      int          dphi;
      int          dr;
      int          dx;
      int          idx;
      bit          take;
      bit          in_strip;
      mean_result_t res;
      case (it.action)
        ACT_BEGIN: begin
          pt = it.ref_pt;
          if (pt < CONE_PT_FLOOR) pt = CONE_PT_FLOOR;
          cone_radius = CONE_NUM / pt;
          if (cone_radius < CONE_MIN) cone_radius = CONE_MIN;
          if (cone_radius > CONE_MAX) cone_radius = CONE_MAX;
          held_eta = it.ref_eta;
          held_phi = it.ref_phi;
          held_three_prong = it.three_prong;
          pt_total = 0;
          weighted_total = 0;
        end
        ACT_PHOTON: begin
          pt = it.cand_pt;
          // drop soft photons
          if (pt < SOFT_PT) return;
          d = int'(it.photon_eta) - held_eta;
          deta = (d < 0) ? -d : d;
          d = int'(it.photon_phi) - held_phi;
          dphi = (d < 0) ? -d : d;
          if (dphi >= FULL_TURN) dphi -= FULL_TURN;
          if (dphi > HALF_TURN) dphi = FULL_TURN - dphi;
          dr = int'(root_floor(longint'(deta) * deta + longint'(dphi) * dphi));
          if (!held_three_prong) begin
            case (select_mode)
              SEL_INNER: take = dr < cone_radius;
              SEL_OUTER: take = dr > cone_radius;
              SEL_ALL:   take = 1'b1;
              default:   take = 1'b0;
            endcase
          end else begin
            idx = (pt > WINDOW_TOP) ? WINDOW_TOP : int'(pt);
            in_strip = dphi <= phi_window[idx] && deta <= eta_window[idx];
            case (select_mode)
              SEL_INNER: take = 1'b1;
              SEL_OUTER: take = in_strip;
              SEL_ALL:   take = !in_strip;
              default:   take = 1'b0;
            endcase
          end
          if (!take) return;
          case (distance_kind)
            DIST_DR:   dx = dr;
            DIST_DETA: dx = deta;
            DIST_DPHI: dx = dphi;
            default:   dx = 0;
          endcase
          pt_total += pt;
          if (pt_total > PT_TOTAL_MAX) pt_total = PT_TOTAL_MAX;
          weighted_total += longint'(pt) * longint'(dx);
          if (weighted_total > WEIGHTED_MAX) weighted_total = WEIGHTED_MAX;
        end
        ACT_FINISH: begin
          res.mean = '0;
          if (pt_total != 0) res.mean = 14'((weighted_total / pt_total > MEAN_CEIL) ?
                                            MEAN_CEIL : weighted_total / pt_total);
          res.any = (pt_total != 0);
          mean_queue.push_back(res);
        end
        default: ;
      endcase
    endfunction

    // Compare one result transfer against the oldest expected mean
    function void check_mean(logic [13:0] mean, logic any);
      mean_result_t want;
      if (mean_queue.size() == 0) begin
        $display("%0t: unexpected result mean_distance %0d any_selected %0b", $time, mean, any);
        failures++;
        return;
      end
      want = mean_queue.pop_front();
      if (want.mean !== mean) begin
        $display("%0t: mean_distance expected %0d actual %0d", $time, want.mean, mean);
        failures++;
      end
      if (want.any !== any) begin
        $display("%0t: any_selected expected %0b actual %0b", $time, want.any, any);
        failures++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         action = '0;
  logic [15:0]        ref_pt = '0;
  logic signed [13:0] ref_eta = '0;
  logic signed [12:0] ref_phi = '0;
  logic               three_prong = 1'b0;
  logic [15:0]        cand_pt = '0;
  logic signed [13:0] photon_eta = '0;
  logic signed [12:0] photon_phi = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [13:0]        mean_distance;
  logic               any_selected;

  photon_mean_board board;
  photon_item_t     last_ref;
  bit               steady_sender = 1'b0;
  int               burst_left = 0;
  int               rx_tick = 0;
  int               hold_left = 0;
  int               stalls_asked = 0;
  int               stalls_done = 0;

  pt_weighted_photon_distance dut (.*);

  initial forever #4 clk = ~clk;

  // Give up after a generous fixed time
  initial begin
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Receiver: long hold when asked, otherwise cycling through always ready, random, a duty pattern and rarely ready
  always @(posedge clk) begin
    rx_tick++;
    if (stalls_asked != stalls_done) begin
      hold_left = LONG_HOLD;
      stalls_done++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case ((rx_tick / 512) % 4)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 1);
        2: out_ready <= ((rx_tick % 7) < 3);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_mean(mean_distance, any_selected);
  end

  // All fields random at full width
  function automatic photon_item_t noise_item(logic [1:0] act);
    photon_item_t it;
    it.action = act;
    it.ref_pt = 16'($urandom());
    it.ref_eta = 14'($urandom());
    it.ref_phi = 13'($urandom());
    it.three_prong = 1'($urandom());
    it.cand_pt = 16'($urandom());
    it.photon_eta = 14'($urandom());
    it.photon_phi = 13'($urandom());
    return it;
  endfunction

  function automatic photon_item_t reference_at(int pt, int eta, int phi, bit tp);
    photon_item_t it;
    it = noise_item(ACT_BEGIN);
    it.ref_pt = 16'(pt);
    it.ref_eta = 14'(eta);
    it.ref_phi = 13'(phi);
    it.three_prong = tp;
    return it;
  endfunction

  function automatic photon_item_t photon_at(int pt, int eta, int phi);
    photon_item_t it;
    it = noise_item(ACT_PHOTON);
    it.cand_pt = 16'(pt);
    it.photon_eta = 14'(eta);
    it.photon_phi = 13'(phi);
    return it;
  endfunction

  // Reference pt mostly where the cone radius moves between its clamps
  function automatic photon_item_t random_reference();
    photon_item_t it;
    it = noise_item(ACT_BEGIN);
    case ($urandom_range(0, 3))
      0: it.ref_pt = 16'($urandom_range(0, 40));
      1, 2: it.ref_pt = 16'($urandom_range(300, 1100));
      default: ;
    endcase
    if ($urandom_range(0, 7) != 0) begin
      it.ref_eta = 14'(int'($urandom_range(0, 10240)) - 5120);
      it.ref_phi = 13'(int'($urandom_range(0, 6434)) - 3217);
    end
    return it;
  endfunction

  // Photons mostly near the reference so cone and strip edges get hit
  function automatic photon_item_t random_photon(photon_item_t ref_it);
    photon_item_t it;
    it = noise_item(ACT_PHOTON);
    case ($urandom_range(0, 5))
      0: it.cand_pt = 16'($urandom_range(0, 15));
      1, 2, 3: it.cand_pt = 16'($urandom_range(8, 300));
      4: it.cand_pt = 16'($urandom_range(256, 4000));
      default: ;
    endcase
    if ($urandom_range(0, 7) != 0) begin
      it.photon_eta = 14'(int'(ref_it.ref_eta) + int'($urandom_range(0, 400)) - 200);
      it.photon_phi = 13'(int'(ref_it.ref_phi) + int'($urandom_range(0, 700)) - 350);
    end else if ($urandom_range(0, 1) == 1) begin
      it.photon_eta = 14'(int'($urandom_range(0, 10240)) - 5120);
      it.photon_phi = 13'(int'($urandom_range(0, 6434)) - 3217);
    end
    return it;
  endfunction

  // Offer one item in bursts with random gaps unless the sender is steady; return after its transfer
  task automatic send_item(photon_item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if (!steady_sender) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
    burst_left--;
    action <= it.action;
    ref_pt <= it.ref_pt;
    ref_eta <= it.ref_eta;
    ref_phi <= it.ref_phi;
    three_prong <= it.three_prong;
    cand_pt <= it.cand_pt;
    photon_eta <= it.photon_eta;
    photon_phi <= it.photon_phi;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    board.absorb_item(it);
  endtask

  // Stop offering, wait for all results, then let a trailing photon finish
  task automatic drain_block();
    in_valid <= 1'b0;
    burst_left = 0;
    while (board.mean_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic idx, logic [1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {30'($urandom()), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board.set_register(idx, value);
  endtask

  // One photon list, usually well formed, sometimes broken or plain noise
  task automatic send_random_list(output int count);
    photon_item_t it;
    int           n;
    count = 0;
    if ($urandom_range(0, 99) < 80) begin
      if ($urandom_range(0, 9) != 0) begin
        last_ref = random_reference();
        send_item(last_ref);
        count++;
      end
      n = $urandom_range(0, 8);
      repeat (n) send_item(random_photon(last_ref));
      send_item(noise_item(ACT_FINISH));
      count += n + 1;
      if ($urandom_range(0, 9) == 0) begin
        send_item(noise_item(ACT_FINISH));
        count++;
      end
    end else begin
      it = noise_item(2'($urandom_range(0, 3)));
      if (it.action == ACT_BEGIN) last_ref = it;
      send_item(it);
      if (it.action != ACT_UNUSED) count = 1;
    end
  endtask

  // Short list of hard, far photons: the mean saturates
  task automatic saturate_mean();
    send_item(reference_at(0, -8192, 0, 1'b0));
    repeat (HARD_PHOTONS) send_item(photon_at(65535, 8191, int'($urandom_range(0, 6434)) - 3217));
    send_item(noise_item(ACT_FINISH));
  endtask

  initial begin
    int         added;
    int         phase_items;
    logic [1:0] sel;
    logic [1:0] kind;
    board = new();
    last_ref = reference_at(0, 0, 0, 1'b0);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, still at the reset configuration
    send_item(photon_at(100, 20, -30));           // photon ahead of any reference
    send_item(noise_item(ACT_FINISH));
    send_item(noise_item(ACT_UNUSED));
    send_item(reference_at(0, -5120, -3217, 1'b0));
    send_item(photon_at(7, -5120, -3217));         // soft, dropped
    send_item(photon_at(8, -5100, -3200));
    send_item(photon_at(65535, -5060, 3217));      // phi difference of a full turn
    send_item(photon_at(200, -5120, -3115));       // right on the cone edge
    send_item(photon_at(200, -5019, -3217));       // just inside it
    send_item(noise_item(ACT_FINISH));
    send_item(noise_item(ACT_FINISH));             // finish again, sums kept
    send_item(reference_at(65535, 5120, 3217, 1'b1));
    send_item(photon_at(255, 5120, 3217));
    send_item(photon_at(65535, -5120, -3217));
    send_item(photon_at(16, 5000, 3000));
    send_item(noise_item(ACT_FINISH));
    send_item(reference_at(32768, -8192, 4095, 1'b0));
    send_item(photon_at(65535, 8191, -4096));
    send_item(photon_at(1000, -8192, 4095));       // zero distance, mean zero but selected
    send_item(noise_item(ACT_FINISH));
    send_item(noise_item(ACT_UNUSED));

    // Random part: walk every select mode against every distance kind
    for (int p = 0; p < 16; p++) begin
      drain_block();
      sel = 2'(p % 4);
      kind = 2'(p / 4);
      write_register(REG_SELECT_MODE, sel);
      write_register(REG_DISTANCE_KIND, kind);
      steady_sender = (p % 5 == 2);
      phase_items = 0;
      if (sel == SEL_ALL && kind == DIST_DR) saturate_mean();
      while (phase_items < PHASE_ITEMS) begin
        // hold the receiver off once while items keep coming
        if (p == 6 && phase_items >= 10 && stalls_asked == 0) stalls_asked++;
        send_random_list(added);
        phase_items += added;
      end
    end

    drain_block();
    if (board.failures == 0 && board.mean_queue.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> files.f
sv/wpd_pkg.sv
sv/pt_weighted_photon_distance.sv
test/pt_weighted_photon_distance_tb.sv
